// ===== rtl/core/flsd_pkg.sv =====
// Shared types, codes and character helpers for the family list splitter decoder.
// Used by flsd_engine and family_list_splitter_decoder; depends on nothing.
package flsd_pkg;

    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_HASH  = 16'h0023;
    localparam logic [15:0] CH_PCT   = 16'h0025;

    localparam logic [1:0] KIND_SRC = 2'd0;
    localparam logic [1:0] KIND_FAM = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_HEX   = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;
    localparam logic [1:0] ERR_OVF   = 2'd3;

    localparam int RESULT_CAP = 32;
    localparam int CNT_W      = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_FIN
    } t_top_state;

    typedef enum logic [2:0] {
        E_IDLE,
        E_INIT,
        E_SCAN,
        E_DECIDE,
        E_SRC,
        E_FAM,
        E_ERR
    } t_eng_state;

    typedef enum logic [1:0] {
        D_NORM,
        D_HEX1,
        D_HEX2
    } t_dec_state;

    typedef struct packed {
        logic start;
        logic step_begin;
        logic overflowed;
    } t_eng_ctl;

    function automatic logic is_space(input logic [15:0] c);
        return (c == 16'h0020) || (c == 16'h0009) || (c == 16'h000D) || (c == 16'h000A);
    endfunction

    function automatic logic hex_ok(input logic [15:0] c);
        return ((c >= 16'h0030) && (c <= 16'h0039)) ||
               ((c >= 16'h0061) && (c <= 16'h0066)) ||
               ((c >= 16'h0041) && (c <= 16'h0046));
    endfunction

    function automatic logic [3:0] hex_val(input logic [15:0] c);
        logic [15:0] t;
        if ((c >= 16'h0030) && (c <= 16'h0039)) begin
            t = c - 16'h0030;
        end else if ((c >= 16'h0061) && (c <= 16'h0066)) begin
            t = c - 16'h0061 + 16'd10;
        end else if ((c >= 16'h0041) && (c <= 16'h0046)) begin
            t = c - 16'h0041 + 16'd10;
        end else begin
            t = 16'h0000;
        end
        return t[3:0];
    endfunction

endpackage

// ===== rtl/core/flsd_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package needed.
module flsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/flsd_engine.sv =====
// Segment finish engine: scans the stored segment, decodes escapes, trims and emits results.
// Depends on flsd_pkg; reads the segment store through the read port of flsd_ram.
module flsd_engine #(
    parameter int MAX_SEGMENT = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  flsd_pkg::t_eng_ctl             i_ctl,
    input  logic [$clog2(MAX_SEGMENT)-1:0] i_fill,
    input  logic [$clog2(MAX_SEGMENT)-1:0] i_fam_lo,
    output logic                           o_done,
    output logic                           o_rd_en,
    output logic [$clog2(MAX_SEGMENT)-1:0] o_rd_addr,
    input  logic [15:0]                    i_rd_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_item_kind,
    output logic [15:0]                    o_char_out,
    output logic [1:0]                     o_error_code,
    output logic                           o_last_of_segment
);

    localparam int AW = $clog2(MAX_SEGMENT);

    flsd_pkg::t_eng_state r_st, n_st;
    flsd_pkg::t_dec_state r_dec, n_dec;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_start, n_start;
    logic [1:0]    r_err, n_err;
    logic [3:0]    r_hi, n_hi;
    logic          r_hi_ok, n_hi_ok;
    logic          r_src_found, n_src_found;
    logic [AW-1:0] r_sa, n_sa;
    logic [AW-1:0] r_sb, n_sb;
    logic          r_fam_found, n_fam_found;
    logic [AW-1:0] r_fa, n_fa;
    logic [AW-1:0] r_fl, n_fl;
    logic [flsd_pkg::CNT_W-1:0] r_cnt;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_char;
    logic [1:0]  r_code;
    logic        r_last;

    logic [AW:0]  pos_p1;
    logic [AW:0]  pos_p2;
    logic [AW:0]  fill_x;
    logic [15:0]  d;
    logic         capped;
    logic         can_put;
    logic         put_en;
    logic [1:0]   put_kind;
    logic [15:0]  put_char;
    logic [1:0]   put_code;
    logic         put_last;
    logic         elem_valid;
    logic [15:0]  elem_val;
    logic [AW-1:0] elem_start;
    logic [15:0]  fam_val;

    assign d       = i_rd_data;
    assign pos_p1  = {1'b0, r_pos} + (AW+1)'(1);
    assign pos_p2  = {1'b0, r_pos} + (AW+1)'(2);
    assign fill_x  = {1'b0, i_fill};
    assign capped  = (r_cnt == flsd_pkg::CNT_W'(flsd_pkg::RESULT_CAP));
    assign can_put = !r_out_valid || !i_out_stall || capped;
    assign fam_val = (r_dec == flsd_pkg::D_HEX2) ? {8'h00, r_hi, flsd_pkg::hex_val(d)} : d;

    always_comb begin
        n_st        = r_st;
        n_dec       = r_dec;
        n_pos       = r_pos;
        n_start     = r_start;
        n_err       = r_err;
        n_hi        = r_hi;
        n_hi_ok     = r_hi_ok;
        n_src_found = r_src_found;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_fam_found = r_fam_found;
        n_fa        = r_fa;
        n_fl        = r_fl;
        o_done      = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_pos + AW'(1);
        put_en      = 1'b0;
        put_kind    = flsd_pkg::KIND_SRC;
        put_char    = 16'h0000;
        put_code    = flsd_pkg::ERR_NONE;
        put_last    = 1'b0;
        elem_valid  = 1'b0;
        elem_val    = d;
        elem_start  = r_pos;
        unique case (r_st)
            flsd_pkg::E_IDLE: begin
                if (i_ctl.start) begin
                    n_st = flsd_pkg::E_INIT;
                end
            end
            flsd_pkg::E_INIT: begin
                n_dec       = flsd_pkg::D_NORM;
                n_src_found = 1'b0;
                n_fam_found = 1'b0;
                if (i_ctl.overflowed) begin
                    n_err = flsd_pkg::ERR_OVF;
                    n_st  = flsd_pkg::E_ERR;
                end else if (i_fill == '0) begin
                    o_done = 1'b1;
                    n_st   = flsd_pkg::E_IDLE;
                end else begin
                    n_err     = flsd_pkg::ERR_NONE;
                    o_rd_en   = 1'b1;
                    o_rd_addr = '0;
                    n_pos     = '0;
                    n_st      = flsd_pkg::E_SCAN;
                end
            end
            flsd_pkg::E_SCAN: begin
                if (r_pos < i_fam_lo) begin
                    if (!flsd_pkg::is_space(d)) begin
                        if (!r_src_found) begin
                            n_sa        = r_pos;
                            n_src_found = 1'b1;
                        end
                        n_sb = r_pos + AW'(1);
                    end
                end else if (r_err == flsd_pkg::ERR_NONE) begin
                    case (r_dec)
                        flsd_pkg::D_NORM: begin
                            if (d == flsd_pkg::CH_PCT) begin
                                if (pos_p2 >= fill_x) begin
                                    n_err = flsd_pkg::ERR_TRUNC;
                                end else begin
                                    n_dec   = flsd_pkg::D_HEX1;
                                    n_start = r_pos;
                                end
                            end else begin
                                elem_valid = 1'b1;
                                elem_val   = d;
                                elem_start = r_pos;
                            end
                        end
                        flsd_pkg::D_HEX1: begin
                            n_hi    = flsd_pkg::hex_val(d);
                            n_hi_ok = flsd_pkg::hex_ok(d);
                            n_dec   = flsd_pkg::D_HEX2;
                        end
                        default: begin
                            n_dec = flsd_pkg::D_NORM;
                            if (!(r_hi_ok && flsd_pkg::hex_ok(d))) begin
                                n_err = flsd_pkg::ERR_HEX;
                            end else begin
                                elem_valid = 1'b1;
                                elem_val   = {8'h00, r_hi, flsd_pkg::hex_val(d)};
                                elem_start = r_start;
                            end
                        end
                    endcase
                    if (elem_valid && !flsd_pkg::is_space(elem_val)) begin
                        if (!r_fam_found) begin
                            n_fa        = elem_start;
                            n_fam_found = 1'b1;
                        end
                        n_fl = r_pos;
                    end
                end
                if (pos_p1 < fill_x) begin
                    o_rd_en = 1'b1;
                    n_pos   = r_pos + AW'(1);
                end else begin
                    n_st = flsd_pkg::E_DECIDE;
                end
            end
            flsd_pkg::E_DECIDE: begin
                n_dec = flsd_pkg::D_NORM;
                if (r_err != flsd_pkg::ERR_NONE) begin
                    n_st = flsd_pkg::E_ERR;
                end else if (!r_fam_found) begin
                    o_done = 1'b1;
                    n_st   = flsd_pkg::E_IDLE;
                end else if (r_src_found) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_sa;
                    n_pos     = r_sa;
                    n_st      = flsd_pkg::E_SRC;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_fa;
                    n_pos     = r_fa;
                    n_st      = flsd_pkg::E_FAM;
                end
            end
            flsd_pkg::E_SRC: begin
                if (can_put) begin
                    put_en   = 1'b1;
                    put_kind = flsd_pkg::KIND_SRC;
                    put_char = d;
                    o_rd_en  = 1'b1;
                    if (pos_p1 < {1'b0, r_sb}) begin
                        n_pos = r_pos + AW'(1);
                    end else begin
                        o_rd_addr = r_fa;
                        n_pos     = r_fa;
                        n_dec     = flsd_pkg::D_NORM;
                        n_st      = flsd_pkg::E_FAM;
                    end
                end
            end
            flsd_pkg::E_FAM: begin
                if ((r_dec == flsd_pkg::D_NORM) && (d == flsd_pkg::CH_PCT)) begin
                    n_dec   = flsd_pkg::D_HEX1;
                    o_rd_en = 1'b1;
                    n_pos   = r_pos + AW'(1);
                end else if (r_dec == flsd_pkg::D_HEX1) begin
                    n_hi    = flsd_pkg::hex_val(d);
                    n_dec   = flsd_pkg::D_HEX2;
                    o_rd_en = 1'b1;
                    n_pos   = r_pos + AW'(1);
                end else if (can_put) begin
                    put_en   = 1'b1;
                    put_kind = flsd_pkg::KIND_FAM;
                    put_char = fam_val;
                    n_dec    = flsd_pkg::D_NORM;
                    if (r_pos == r_fl) begin
                        put_last = 1'b1;
                        o_done   = 1'b1;
                        n_st     = flsd_pkg::E_IDLE;
                    end else begin
                        o_rd_en = 1'b1;
                        n_pos   = r_pos + AW'(1);
                    end
                end
            end
            flsd_pkg::E_ERR: begin
                if (can_put) begin
                    put_en   = 1'b1;
                    put_kind = flsd_pkg::KIND_ERR;
                    put_code = r_err;
                    put_last = 1'b1;
                    o_done   = 1'b1;
                    n_st     = flsd_pkg::E_IDLE;
                end
            end
            default: begin
                n_st = flsd_pkg::E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= flsd_pkg::E_IDLE;
            r_dec       <= flsd_pkg::D_NORM;
            r_err       <= flsd_pkg::ERR_NONE;
            r_src_found <= 1'b0;
            r_fam_found <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_dec       <= n_dec;
            r_err       <= n_err;
            r_src_found <= n_src_found;
            r_fam_found <= n_fam_found;
            if (i_ctl.step_begin) begin
                r_cnt <= '0;
            end else if (put_en && !capped) begin
                r_cnt <= r_cnt + flsd_pkg::CNT_W'(1);
            end
            if (put_en && !capped) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_start <= n_start;
        r_hi    <= n_hi;
        r_hi_ok <= n_hi_ok;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_fa    <= n_fa;
        r_fl    <= n_fl;
        if (put_en && !capped) begin
            r_kind <= put_kind;
            r_char <= put_char;
            r_code <= put_code;
            r_last <= put_last || (r_cnt == flsd_pkg::CNT_W'(flsd_pkg::RESULT_CAP - 1));
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_item_kind       = r_kind;
    assign o_char_out        = r_char;
    assign o_error_code      = r_code;
    assign o_last_of_segment = r_last;

endmodule

// ===== rtl/core/family_list_splitter_decoder.sv =====
// Top level of the family list splitter decoder: character intake, segment state, store.
// Depends on flsd_pkg, flsd_ram and flsd_engine.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_stall      i_char_in, i_end_of_string
//   result    out        o_out_valid / i_out_stall    o_item_kind, o_char_out,
//                                                     o_error_code, o_last_of_segment
//
// A character that ends no segment is first accepted, then used to update the store.
// A segment end adds the engine's two passes over the store read port (one to scan and
// decode, one to emit), and the engine waits while the result side stalls.
// A character that follows a single comma is handled once more after the finish.
// Reset is synchronous and active low; the store itself is not cleared.
// While a segment is being finished the input side is stalled.
module family_list_splitter_decoder #(
    parameter int MAX_SEGMENT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_char_in,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_item_kind,
    output logic [15:0] o_char_out,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_segment
);

    localparam int AW = $clog2(MAX_SEGMENT);

    flsd_pkg::t_top_state r_state, n_state;
    logic [15:0]   r_c;
    logic          r_eos;
    logic [AW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_hpos, n_hpos;
    logic          r_hash_seen, n_hash_seen;
    logic          r_pending, n_pending;
    logic          r_skip, n_skip;
    logic          r_ovf, n_ovf;
    logic          r_again, n_again;

    logic               accept;
    logic               keep_req;
    logic [15:0]        keep_val;
    logic               wr_en;
    logic               fin_go;
    logic               eng_done;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [15:0]        rd_data;
    logic [AW-1:0]      fam_lo;
    flsd_pkg::t_eng_ctl eng_ctl;

    assign o_in_stall = (r_state != flsd_pkg::ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign fam_lo     = r_hash_seen ? r_hpos : '0;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_hpos      = r_hpos;
        n_hash_seen = r_hash_seen;
        n_pending   = r_pending;
        n_skip      = r_skip;
        n_ovf       = r_ovf;
        n_again     = r_again;
        keep_req    = 1'b0;
        keep_val    = r_c;
        wr_en       = 1'b0;
        fin_go      = 1'b0;
        unique case (r_state)
            flsd_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = flsd_pkg::ST_PROC;
                end
            end
            flsd_pkg::ST_PROC: begin
                n_again = 1'b0;
                if (r_pending) begin
                    n_pending = 1'b0;
                    if (r_c == flsd_pkg::CH_COMMA) begin
                        keep_req = 1'b1;
                        keep_val = flsd_pkg::CH_COMMA;
                        n_skip   = 1'b0;
                        fin_go   = r_eos;
                    end else begin
                        fin_go  = 1'b1;
                        n_again = 1'b1;
                    end
                end else if (r_skip && flsd_pkg::is_space(r_c)) begin
                    fin_go = r_eos;
                end else begin
                    n_skip = 1'b0;
                    if (r_c == flsd_pkg::CH_COMMA) begin
                        fin_go    = r_eos;
                        n_pending = !r_eos;
                    end else begin
                        if ((r_c == flsd_pkg::CH_HASH) && !r_hash_seen) begin
                            n_hash_seen = 1'b1;
                            n_hpos      = r_fill;
                        end else begin
                            keep_req = 1'b1;
                        end
                        fin_go = r_eos;
                    end
                end
                if (keep_req) begin
                    if (r_fill < AW'(MAX_SEGMENT - 1)) begin
                        wr_en  = 1'b1;
                        n_fill = r_fill + AW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = fin_go ? flsd_pkg::ST_FIN : flsd_pkg::ST_IDLE;
            end
            flsd_pkg::ST_FIN: begin
                if (eng_done) begin
                    n_fill      = '0;
                    n_hpos      = '0;
                    n_hash_seen = 1'b0;
                    n_pending   = 1'b0;
                    n_skip      = 1'b1;
                    n_ovf       = 1'b0;
                    n_state     = r_again ? flsd_pkg::ST_PROC : flsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = flsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flsd_pkg::ST_IDLE;
            r_fill      <= '0;
            r_hpos      <= '0;
            r_hash_seen <= 1'b0;
            r_pending   <= 1'b0;
            r_skip      <= 1'b1;
            r_ovf       <= 1'b0;
            r_again     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_hpos      <= n_hpos;
            r_hash_seen <= n_hash_seen;
            r_pending   <= n_pending;
            r_skip      <= n_skip;
            r_ovf       <= n_ovf;
            r_again     <= n_again;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c   <= i_char_in;
            r_eos <= i_end_of_string;
        end
    end

    assign eng_ctl.start      = fin_go;
    assign eng_ctl.step_begin = accept;
    assign eng_ctl.overflowed = r_ovf;

    flsd_ram #(
        .WIDTH(16),
        .DEPTH(MAX_SEGMENT)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_fill),
        .i_wr_data(keep_val),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    flsd_engine #(
        .MAX_SEGMENT(MAX_SEGMENT)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (eng_ctl),
        .i_fill           (r_fill),
        .i_fam_lo         (fam_lo),
        .o_done           (eng_done),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_item_kind      (o_item_kind),
        .o_char_out       (o_char_out),
        .o_error_code     (o_error_code),
        .o_last_of_segment(o_last_of_segment)
    );

`ifndef SYNTHESIS
    a_no_write_while_finishing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == flsd_pkg::ST_FIN) |-> !wr_en)
        else $error("segment store written while a segment is being finished");

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= AW'(MAX_SEGMENT - 1))
        else $error("fill count beyond the reserved last entry");

    a_hash_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hash_seen |-> (r_hpos <= r_fill))
        else $error("hash position beyond fill count");

    a_error_closes_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_item_kind == flsd_pkg::KIND_ERR)) |-> o_last_of_segment)
        else $error("error request without end of segment");
`endif

endmodule

// ===== bench/family_list_splitter_decoder_tb.sv =====
// Self-checking testbench for family_list_splitter_decoder: sends comma-separated lists
// and compares every result with a scoreboard that predicts the segment output.
// Depends on flsd_pkg and the RTL of the block; needs no files or arguments.
module family_list_splitter_decoder_tb;

    import flsd_pkg::*;

    localparam int SEG_DEPTH   = 32;
    localparam int RANDOM_REQS = 430;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ch;
        logic [1:0]  err;
        logic        last;
    } t_seg_result;

    class segment_scoreboard;
        logic [15:0] seg_chars [SEG_DEPTH];
        int          fill;
        int          hash_at;
        bit          hash_seen;
        bit          comma_held;
        bit          skip_blank;
        bit          overflow;
        int          step_results;
        int          mismatches;
        t_seg_result due[$];

        function new();
            mismatches = 0;
            clear_segment();
        endfunction

        function void clear_segment();
            fill       = 0;
            hash_at    = 0;
            hash_seen  = 1'b0;
            comma_held = 1'b0;
            skip_blank = 1'b1;
            overflow   = 1'b0;
        endfunction

        function bit blank(logic [15:0] c);
            return c == 16'h0020 || c == 16'h0009 || c == 16'h000D || c == 16'h000A;
        endfunction

        function int nibble(logic [15:0] c);
            if (c >= 16'h0030 && c <= 16'h0039) return int'(c) - 'h30;
            if (c >= 16'h0061 && c <= 16'h0066) return int'(c) - 'h61 + 10;
            if (c >= 16'h0041 && c <= 16'h0046) return int'(c) - 'h41 + 10;
            return -1;
        endfunction

        function void add(logic [1:0] kind, logic [15:0] ch, logic [1:0] err);
            t_seg_result r;
            if (step_results >= RESULT_CAP) return;
            r.kind = kind;
            r.ch   = ch;
            r.err  = err;
            r.last = 1'b0;
            due.push_back(r);
            step_results++;
        endfunction

        function void keep(logic [15:0] c);
            if (fill < SEG_DEPTH - 1) begin
                seg_chars[fill] = c;
                fill++;
            end else begin
                overflow = 1'b1;
            end
        endfunction

        function void close_segment();
            logic [15:0] decoded[$];
            logic [15:0] c;
            logic [1:0]  err;
            int          fam_lo, i, a, b, s0, s1, hi, lo, start;
            t_seg_result r;
            start  = step_results;
            err    = ERR_NONE;
            fam_lo = hash_seen ? hash_at : 0;
            if (fam_lo > fill) fam_lo = fill;
            if (overflow) begin
                add(KIND_ERR, 16'h0000, ERR_OVF);
            end else begin
                i = fam_lo;
                while (i < fill && decoded.size() < SEG_DEPTH) begin
                    c = seg_chars[i];
                    if (c == CH_PCT) begin
                        if (i + 2 >= fill) begin
                            err = ERR_TRUNC;
                            break;
                        end
                        hi = nibble(seg_chars[i + 1]);
                        lo = nibble(seg_chars[i + 2]);
                        if (hi < 0 || lo < 0) begin
                            err = ERR_HEX;
                            break;
                        end
                        c = 16'(hi * 16 + lo);
                        i += 2;
                    end
                    decoded.push_back(c);
                    i++;
                end
                if (err != ERR_NONE) begin
                    add(KIND_ERR, 16'h0000, err);
                end else begin
                    a = 0;
                    b = decoded.size();
                    while (a < b && blank(decoded[a])) a++;
                    while (b > a && blank(decoded[b - 1])) b--;
                    if (a < b) begin
                        s0 = 0;
                        s1 = fam_lo;
                        while (s0 < s1 && blank(seg_chars[s0])) s0++;
                        while (s1 > s0 && blank(seg_chars[s1 - 1])) s1--;
                        for (i = s0; i < s1; i++) add(KIND_SRC, seg_chars[i], ERR_NONE);
                        for (i = a; i < b; i++) add(KIND_FAM, decoded[i], ERR_NONE);
                    end
                end
            end
            if (step_results > start) begin
                r = due.pop_back();
                r.last = 1'b1;
                due.push_back(r);
            end
            clear_segment();
        endfunction

        function void take_char(logic [15:0] c, logic eos);
            step_results = 0;
            if (comma_held) begin
                comma_held = 1'b0;
                if (c == CH_COMMA) begin
                    keep(CH_COMMA);
                    skip_blank = 1'b0;
                    if (eos) close_segment();
                    return;
                end
                close_segment();
            end
            if (skip_blank && blank(c)) begin
                if (eos) close_segment();
                return;
            end
            skip_blank = 1'b0;
            if (c == CH_COMMA) begin
                if (eos) close_segment();
                else comma_held = 1'b1;
                return;
            end
            if (c == CH_HASH && !hash_seen) begin
                hash_seen = 1'b1;
                hash_at   = fill;
            end else begin
                keep(c);
            end
            if (eos) close_segment();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        function void check_result(t_seg_result got);
            t_seg_result want;
            if (due.size() == 0) begin
                flag($sformatf("unexpected result kind=%0d char=%h err=%0d last=%0d",
                               got.kind, got.ch, got.err, got.last));
                return;
            end
            want = due.pop_front();
            if (got.kind !== want.kind || got.ch !== want.ch || got.err !== want.err ||
                got.last !== want.last) begin
                flag({$sformatf("expected kind=%0d char=%h err=%0d last=%0d",
                                want.kind, want.ch, want.err, want.last),
                      $sformatf(", got kind=%0d char=%h err=%0d last=%0d",
                                got.kind, got.ch, got.err, got.last)});
            end
        endfunction

        function int due_count();
            return due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_char_in;
    logic        i_end_of_string;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_item_kind;
    logic [15:0] o_char_out;
    logic [1:0]  o_error_code;
    logic        o_last_of_segment;

    segment_scoreboard sb;
    logic [16:0]       list_chars[$];
    int                sent;
    int                burst_left  = 0;
    int                stall_level = 0;
    int                stall_span  = 0;

    family_list_splitter_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_char_in         (i_char_in),
        .i_end_of_string   (i_end_of_string),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_item_kind       (o_item_kind),
        .o_char_out        (o_char_out),
        .o_error_code      (o_error_code),
        .o_last_of_segment (o_last_of_segment)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result('{o_item_kind, o_char_out, o_error_code, o_last_of_segment});
        end
        if (stall_span == 0) begin
            stall_span  = $urandom_range(16, 80);
            stall_level = $urandom_range(0, 3);
        end
        stall_span--;
        i_out_stall <= ($urandom_range(0, 3) < stall_level);
    end

    task automatic send_char(input logic [15:0] c, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_in_valid      <= 1'b1;
        i_char_in       <= c;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_char(c, eos);
        burst_left--;
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(16'(s[k]), 1'b0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_count() > 0) @(posedge i_clk);
    endtask

    function automatic void push_char(logic [15:0] c);
        list_chars.push_back({1'b0, c});
    endfunction

    function automatic logic [15:0] blank_char();
        case ($urandom_range(0, 3))
            0: return 16'h0020;
            1: return 16'h0009;
            2: return 16'h000D;
            default: return 16'h000A;
        endcase
    endfunction

    function automatic logic [15:0] hex_digit_char();
        string digits = "0123456789abcdefABCDEF";
        return 16'(digits[$urandom_range(0, 21)]);
    endfunction

    function automatic logic [15:0] bad_digit_char();
        case ($urandom_range(0, 5))
            0: return 16'h0067;
            1: return 16'h0047;
            2: return 16'h002F;
            3: return 16'h003A;
            4: return 16'h0040;
            default: return 16'h0060;
        endcase
    endfunction

    function automatic logic [15:0] text_char();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'h0030 + 16'($urandom_range(0, 9));
            2: return 16'h0041 + 16'($urandom_range(0, 25));
            default: return 16'h0061 + 16'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic void make_list();
        int          segs, len, mode, k;
        logic [16:0] tail;
        list_chars.delete();
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++) begin
            if (s > 0) push_char(CH_COMMA);
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                repeat ($urandom_range(1, 8)) push_char(16'($urandom_range(0, 65535)));
            end else if (mode == 1) begin
                len = $urandom_range(26, 40);
                for (k = 0; k < len; k++) begin
                    push_char((k == len / 3) ? CH_HASH : text_char());
                end
            end else begin
                repeat ($urandom_range(0, 2)) push_char(blank_char());
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(0, 7) == 0) begin
                        push_char(CH_COMMA);
                        push_char(CH_COMMA);
                    end else begin
                        push_char(text_char());
                    end
                end
                if ($urandom_range(0, 7) != 0) push_char(CH_HASH);
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            push_char(CH_PCT);
                            push_char(hex_digit_char());
                            push_char(hex_digit_char());
                        end
                        1: push_char(blank_char());
                        default: push_char(text_char());
                    endcase
                end
                case ($urandom_range(0, 11))
                    0: begin
                        push_char(CH_PCT);
                        if ($urandom_range(0, 1)) begin
                            push_char(bad_digit_char());
                            push_char(hex_digit_char());
                        end else begin
                            push_char(hex_digit_char());
                            push_char(bad_digit_char());
                        end
                    end
                    1: begin
                        push_char(CH_PCT);
                        if ($urandom_range(0, 1)) push_char(hex_digit_char());
                    end
                    default: ;
                endcase
                repeat ($urandom_range(0, 2)) push_char(blank_char());
            end
        end
        if ($urandom_range(0, 3) == 0) push_char(CH_COMMA);
        if (list_chars.size() == 0) push_char(text_char());
        tail = list_chars.pop_back();
        list_chars.push_back({1'b1, tail[15:0]});
    endfunction

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        sent = 0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_char_in       <= 16'h0000;
        i_end_of_string <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leading blanks, an escape, a literal comma, a later hash, an empty family,
        // a truncated escape, a bad hex digit and the extreme character codes.
        send_text("\tA#%4a ,,#B,x# ,#%4,#%g1,");
        send_char(16'hFFFF, 1'b0);
        send_char(16'h0000, 1'b1);
        wait_drained();

        sent = 0;
        while (sent < RANDOM_REQS) begin
            make_list();
            foreach (list_chars[k]) send_char(list_chars[k][15:0], list_chars[k][16]);
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.due_count() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
